[rtl/acc_pkg.sv]
// Shared types, constants and arithmetic steps for the tilt and vibration block.
// Used by acc_front, acc_fifo, acc_back and the top level; depends on nothing.
package acc_pkg;

    localparam int AXIS_W       = 16;
    localparam int MAG_W        = AXIS_W + 1;
    localparam int SUM_W        = 32;
    localparam int RAD_W        = SUM_W + 16;
    localparam int ROOT_W       = RAD_W / 2;
    localparam int SQRT_STEPS   = ROOT_W;
    localparam int CORDIC_STEPS = 16;
    localparam int CW           = 28;
    localparam int ANG_FRAC     = 12;
    localparam int TILT_W       = 15;
    localparam int TILT_MAX     = 9000;
    localparam int ONEG_W       = 15;
    localparam int VIB_W        = 16;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    // One classified sample: the three sums of squares and the two numerators.
    typedef struct packed {
        logic [SUM_W-1:0] s_xz;
        logic [SUM_W-1:0] s_yz;
        logic [SUM_W-1:0] s_all;
        logic [MAG_W-1:0] num_tx;
        logic [MAG_W-1:0] num_ty;
        logic             neg_tx;
        logic             neg_ty;
    } t_item;

    // Square root digit state.
    typedef struct packed {
        logic [RAD_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

    // CORDIC vector and angle.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // atan(2^-i) in hundredths of a degree with 12 fraction bits.
    function automatic logic signed [CW-1:0] atan_entry(input int i);
        logic signed [CW-1:0] v;
        case (i)
            0:  v = 28'sd18432000;
            1:  v = 28'sd10881045;
            2:  v = 28'sd5749245;
            3:  v = 28'sd2918407;
            4:  v = 28'sd1464867;
            5:  v = 28'sd733147;
            6:  v = 28'sd366663;
            7:  v = 28'sd183343;
            8:  v = 28'sd91673;
            9:  v = 28'sd45837;
            10: v = 28'sd22918;
            11: v = 28'sd11459;
            12: v = 28'sd5730;
            13: v = 28'sd2865;
            14: v = 28'sd1432;
            15: v = 28'sd716;
            16: v = 28'sd358;
            17: v = 28'sd179;
            18: v = 28'sd90;
            19: v = 28'sd45;
            20: v = 28'sd22;
            21: v = 28'sd11;
            22: v = 28'sd6;
            23: v = 28'sd3;
            default: v = '0;
        endcase
        return v;
    endfunction

    // One result bit of the restoring square root at bit position b.
    function automatic t_sqrt sqrt_step(input t_sqrt s, input int b);
        t_sqrt            o;
        logic [RAD_W:0]   t;
        t = ({{(RAD_W-ROOT_W+1){1'b0}}, s.root} << (b + 1))
            + ({{RAD_W{1'b0}}, 1'b1} << (2 * b));
        o = s;
        if ({1'b0, s.rem} >= t) begin
            o.rem  = s.rem - t[RAD_W-1:0];
            o.root = s.root | ({{(ROOT_W-1){1'b0}}, 1'b1} << b);
        end
        return o;
    endfunction

    // One vectoring rotation with floor shifts by i.
    function automatic t_cordic cordic_step(input t_cordic c, input int i);
        t_cordic o;
        o = c;
        if (c.y > 0) begin
            o.x = c.x + (c.y >>> i);
            o.y = c.y - (c.x >>> i);
            o.z = c.z + atan_entry(i);
        end else if (c.y < 0) begin
            o.x = c.x - (c.y >>> i);
            o.y = c.y + (c.x >>> i);
            o.z = c.z - atan_entry(i);
        end
        return o;
    endfunction

    // Round the angle, hold it to the range and apply the sign.
    function automatic logic [TILT_W-1:0] tilt_finish(input logic signed [CW-1:0] z,
                                                      input logic neg, input logic zero);
        logic [CW-1:0]     r;
        logic [TILT_W-1:0] t;
        r = '0;
        if (z >= 0) begin
            r = CW'((z + CW'(1 << (ANG_FRAC - 1))) >>> ANG_FRAC);
        end
        if (r > CW'(TILT_MAX)) begin
            t = TILT_W'(TILT_MAX);
        end else begin
            t = r[TILT_W-1:0];
        end
        if (zero) begin
            t = '0;
        end else if (neg) begin
            t = TILT_W'(-t);
        end
        return t;
    endfunction

endpackage

[rtl/acc_front.sv]
// Front end: takes a sample, squares the axes and classifies the numerators.
// Depends on acc_pkg; feeds acc_fifo.
module acc_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [acc_pkg::AXIS_W-1:0]  i_accel_x,
    input  logic signed [acc_pkg::AXIS_W-1:0]  i_accel_y,
    input  logic signed [acc_pkg::AXIS_W-1:0]  i_accel_z,
    input  acc_pkg::t_fifo_stat                i_fifo_stat,
    output logic                               o_push,
    output acc_pkg::t_item                     o_item
);
    import acc_pkg::*;

    logic             r_valid;
    logic [SUM_W-1:0] r_xx, r_yy, r_zz;
    logic [MAG_W-1:0] r_ax, r_ay;
    logic             r_neg_tx, r_neg_ty;
    logic             accept;
    logic [MAG_W-1:0] n_ax, n_ay;

    // The stage holds while its square sums cannot enter the queue.
    assign o_stall = r_valid && i_fifo_stat.full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_fifo_stat.full;

    // Magnitudes of the axes; the most negative count becomes +32768.
    assign n_ax = i_accel_x[AXIS_W-1] ? MAG_W'(-{i_accel_x[AXIS_W-1], i_accel_x})
                                      : MAG_W'({1'b0, i_accel_x});
    assign n_ay = i_accel_y[AXIS_W-1] ? MAG_W'(-{i_accel_y[AXIS_W-1], i_accel_y})
                                      : MAG_W'({1'b0, i_accel_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // Squares and signs of the two numerators.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_xx     <= SUM_W'(i_accel_x * i_accel_x);
            r_yy     <= SUM_W'(i_accel_y * i_accel_y);
            r_zz     <= SUM_W'(i_accel_z * i_accel_z);
            r_ax     <= n_ax;
            r_ay     <= n_ay;
            r_neg_tx <= i_accel_y[AXIS_W-1];
            r_neg_ty <= !i_accel_x[AXIS_W-1] && (i_accel_x != '0);
        end
    end

    // Sums for the three square roots.
    always_comb begin
        o_item.s_xz   = r_xx + r_zz;
        o_item.s_yz   = r_yy + r_zz;
        o_item.s_all  = r_xx + r_yy + r_zz;
        o_item.num_tx = r_ay;
        o_item.num_ty = r_ax;
        o_item.neg_tx = r_neg_tx;
        o_item.neg_ty = r_neg_ty;
    end

endmodule

[rtl/acc_fifo.sv]
// Short queue between the front end and the arithmetic pipeline.
// Depends on acc_pkg.
module acc_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  acc_pkg::t_item      i_item,
    input  logic                i_pop,
    output acc_pkg::t_item      o_item,
    output acc_pkg::t_fifo_stat o_stat
);
    import acc_pkg::*;

    t_item              r_mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_AW:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_item       = r_mem[r_rd];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue level out of range");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue level missed a request");

endmodule

[rtl/acc_back.sv]
// Arithmetic pipeline: three square roots, two CORDIC atan2 units, vibration.
// Depends on acc_pkg; reads entries from acc_fifo.
module acc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  acc_pkg::t_item                    i_item,
    input  acc_pkg::t_fifo_stat               i_fifo_stat,
    output logic                              o_pop,
    input  logic [acc_pkg::ONEG_W-1:0]        i_one_g,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [acc_pkg::TILT_W-1:0] o_tilt_x,
    output logic signed [acc_pkg::TILT_W-1:0] o_tilt_y,
    output logic [acc_pkg::VIB_W-1:0]         o_vibration
);
    import acc_pkg::*;

    logic             adv;
    logic             r_out_valid;
    logic [TILT_W-1:0] r_tx, r_ty;
    logic [VIB_W-1:0]  r_vib;

    // Square root stages: lane 0 for tilt x, lane 1 for tilt y, lane 2 magnitude.
    logic             r_sv   [0:SQRT_STEPS];
    t_sqrt            r_sq   [0:SQRT_STEPS][0:2];
    logic [MAG_W-1:0] r_snum [0:SQRT_STEPS][0:1];
    logic             r_sneg [0:SQRT_STEPS][0:1];

    // CORDIC stages.
    logic              r_cv   [1:CORDIC_STEPS];
    t_cordic           r_cc   [1:CORDIC_STEPS][0:1];
    logic              r_cneg [1:CORDIC_STEPS][0:1];
    logic              r_czer [1:CORDIC_STEPS][0:1];
    logic [ROOT_W-1:0] r_cmag [1:CORDIC_STEPS];
    t_cordic           s_cc   [0:CORDIC_STEPS-1][0:1];

    logic [ROOT_W-1:0] ref_g, dev;
    logic [ROOT_W:0]   vib_r;

    // The whole pipeline moves whenever the output register can take data.
    assign adv   = !r_out_valid || !i_stall;
    assign o_pop = adv && !i_fifo_stat.empty;

    // Stage entry: radicands scaled by 2^16.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (adv) begin
            r_sv[0] <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq[0][0]   <= '{rem: {i_item.s_xz, 16'd0}, root: '0};
            r_sq[0][1]   <= '{rem: {i_item.s_yz, 16'd0}, root: '0};
            r_sq[0][2]   <= '{rem: {i_item.s_all, 16'd0}, root: '0};
            r_snum[0][0] <= i_item.num_tx;
            r_snum[0][1] <= i_item.num_ty;
            r_sneg[0][0] <= i_item.neg_tx;
            r_sneg[0][1] <= i_item.neg_ty;
        end
    end

    // One root bit per stage, most significant first.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (adv) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int l = 0; l < 3; l++) begin
                    r_sq[k+1][l] <= sqrt_step(r_sq[k][l], SQRT_STEPS - 1 - k);
                end
                for (int l = 0; l < 2; l++) begin
                    r_snum[k+1][l] <= r_snum[k][l];
                    r_sneg[k+1][l] <= r_sneg[k][l];
                end
            end
        end
    end

    // One rotation per stage; the first takes (D, N) from the roots.
    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
        if (j == 0) begin : g_first
            for (genvar l = 0; l < 2; l++) begin : g_lane
                assign s_cc[0][l].x = CW'({1'b0, r_sq[SQRT_STEPS][l].root});
                assign s_cc[0][l].y = CW'({r_snum[SQRT_STEPS][l], 8'd0});
                assign s_cc[0][l].z = '0;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cv[1] <= 1'b0;
                end else if (adv) begin
                    r_cv[1] <= r_sv[SQRT_STEPS];
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    for (int l = 0; l < 2; l++) begin
                        r_cc[1][l]   <= cordic_step(s_cc[0][l], 0);
                        r_cneg[1][l] <= r_sneg[SQRT_STEPS][l];
                        r_czer[1][l] <= (r_snum[SQRT_STEPS][l] == '0);
                    end
                    r_cmag[1] <= r_sq[SQRT_STEPS][2].root;
                end
            end
        end else begin : g_rest
            for (genvar l = 0; l < 2; l++) begin : g_lane
                assign s_cc[j][l] = r_cc[j][l];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cv[j+1] <= 1'b0;
                end else if (adv) begin
                    r_cv[j+1] <= r_cv[j];
                end
            end

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    for (int l = 0; l < 2; l++) begin
                        r_cc[j+1][l]   <= cordic_step(s_cc[j][l], j);
                        r_cneg[j+1][l] <= r_cneg[j][l];
                        r_czer[j+1][l] <= r_czer[j][l];
                    end
                    r_cmag[j+1] <= r_cmag[j];
                end
            end
        end
    end

    // Deviation of the magnitude from one g, rounded and saturated.
    always_comb begin
        ref_g = ROOT_W'({i_one_g, 8'd0});
        dev   = (r_cmag[CORDIC_STEPS] >= ref_g) ? (r_cmag[CORDIC_STEPS] - ref_g)
                                                : (ref_g - r_cmag[CORDIC_STEPS]);
        vib_r = (ROOT_W+1)'(({1'b0, dev} + (ROOT_W+1)'(128)) >> 8);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_cv[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tx  <= tilt_finish(r_cc[CORDIC_STEPS][0].z, r_cneg[CORDIC_STEPS][0],
                                 r_czer[CORDIC_STEPS][0]);
            r_ty  <= tilt_finish(r_cc[CORDIC_STEPS][1].z, r_cneg[CORDIC_STEPS][1],
                                 r_czer[CORDIC_STEPS][1]);
            r_vib <= (vib_r > (ROOT_W+1)'(65535)) ? VIB_W'(65535) : vib_r[VIB_W-1:0];
        end
    end

    assign o_valid     = r_out_valid;
    assign o_tilt_x    = r_tx;
    assign o_tilt_y    = r_ty;
    assign o_vibration = r_vib;

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_sv[0]) else $error("popped request did not enter the pipeline");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid && $stable(r_tx) && $stable(r_vib))
        else $error("stalled result changed");
    a_tilt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed(r_tx) <= 15'sd9000 && $signed(r_tx) >= -15'sd9000))
        else $error("tilt out of range");

endmodule

[rtl/accel_tilt_and_vibration.sv]
// Top level of the accelerometer tilt and vibration block.
// Depends on acc_pkg, acc_front, acc_fifo and acc_back.
//
//  channel   direction  handshake                  payload
//  sample    in         i_valid / o_stall          i_accel_x, i_accel_y, i_accel_z
//  result    out        o_valid / i_stall          o_tilt_x, o_tilt_y, o_vibration
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (one_g_counts)
//
// One sample per cycle is taken at full rate while o_stall is low; each result passes
// through one front stage, one queue slot, 25 square root stages, 16 CORDIC
// stages and the output register. Reset is synchronous, active low, and sets
// one g to 16384. A stalled output freezes the arithmetic pipeline; the 4-entry
// queue and the front stage absorb samples until they fill, then o_stall rises.
module accel_tilt_and_vibration (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [acc_pkg::AXIS_W-1:0]  i_accel_x,
    input  logic signed [acc_pkg::AXIS_W-1:0]  i_accel_y,
    input  logic signed [acc_pkg::AXIS_W-1:0]  i_accel_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [acc_pkg::TILT_W-1:0]  o_tilt_x,
    output logic signed [acc_pkg::TILT_W-1:0]  o_tilt_y,
    output logic [acc_pkg::VIB_W-1:0]          o_vibration,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [acc_pkg::ONEG_W-1:0]         i_cfg_data
);
    import acc_pkg::*;

    logic [ONEG_W-1:0] r_one_g_counts;
    logic             push, pop;
    t_item            f_item, q_item;
    t_fifo_stat       stat;

    assign o_cfg_ready = 1'b1;

    // One g register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_g_counts <= ONEG_W'(16384);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_one_g_counts <= i_cfg_data;
        end
    end

    acc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_fifo_stat (stat),
        .o_push      (push),
        .o_item      (f_item)
    );

    acc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_stat  (stat)
    );

    acc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (q_item),
        .i_fifo_stat (stat),
        .o_pop       (pop),
        .i_one_g     (r_one_g_counts),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tilt_x    (o_tilt_x),
        .o_tilt_y    (o_tilt_y),
        .o_vibration (o_vibration)
    );

endmodule

[verif/tb_top.sv]
// Self-checking testbench for accel_tilt_and_vibration: it predicts tilt and
// vibration per sample and compares them in order. Depends on acc_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import acc_pkg::*;

    typedef struct packed {
        logic [TILT_W-1:0] tilt_x;
        logic [TILT_W-1:0] tilt_y;
        logic [VIB_W-1:0]  vibration;
    } t_tilt_vib;

    // Tracks the one g setting and the tilt and vibration each request should produce.
    class tilt_vib_board;
        t_tilt_vib         pending_tilts[$];
        longint unsigned   one_g;
        int                errs;

        function new();
            one_g = 16384;
            errs  = 0;
        endfunction

        // Floor square root, one result bit at a time.
        function longint unsigned root_floor(input longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // Vectoring rotation from (sqrt(den_sq), |num|) to the angle in hundredths.
        function logic [TILT_W-1:0] tilt_angle(input longint num, input longint unsigned den_sq);
            longint angles[24] = '{18432000, 10881045, 5749245, 2918407, 1464867,
                                   733147, 366663, 183343, 91673, 45837, 22918, 11459,
                                   5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3};
            longint vx, vy, acc, nx, t;
            bit neg;
            neg = num < 0;
            vx  = longint'(root_floor(den_sq << 16));
            vy  = (neg ? -num : num) * 256;
            acc = 0;
            if (vy == 0) return '0;
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                if (vy > 0) begin
                    nx  = vx + (vy >>> i);
                    vy  = vy - (vx >>> i);
                    vx  = nx;
                    acc = acc + angles[i];
                end else if (vy < 0) begin
                    nx  = vx - (vy >>> i);
                    vy  = vy + (vx >>> i);
                    vx  = nx;
                    acc = acc - angles[i];
                end
            end
            t = (acc < 0) ? 0 : ((acc + 2048) >>> 12);
            if (t > TILT_MAX) t = TILT_MAX;
            return TILT_W'(neg ? -t : t);
        endfunction

        // Work out the result of one accepted sample.
        function void note_sample(input logic signed [AXIS_W-1:0] x,
                                  input logic signed [AXIS_W-1:0] y,
                                  input logic signed [AXIS_W-1:0] z);
            longint ax, ay, az;
            longint unsigned mag, ref_g, dev, vib;
            t_tilt_vib e;
            ax = x;
            ay = y;
            az = z;
            e.tilt_x = tilt_angle(ay, ax * ax + az * az);
            e.tilt_y = tilt_angle(-ax, ay * ay + az * az);
            mag   = root_floor((ax * ax + ay * ay + az * az) << 16);
            ref_g = one_g << 8;
            dev   = (mag >= ref_g) ? mag - ref_g : ref_g - mag;
            vib   = (dev + 128) >> 8;
            if (vib > 65535) vib = 65535;
            e.vibration = vib[VIB_W-1:0];
            pending_tilts.push_back(e);
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(input t_tilt_vib got);
            t_tilt_vib e;
            if (pending_tilts.size() == 0) begin
                $error("unexpected result: tilt_x %0d tilt_y %0d vibration %0d",
                       $signed(got.tilt_x), $signed(got.tilt_y), got.vibration);
                errs++;
                return;
            end
            e = pending_tilts.pop_front();
            if (got.tilt_x !== e.tilt_x) begin
                $error("tilt_x expected %0d actual %0d", $signed(e.tilt_x), $signed(got.tilt_x));
                errs++;
            end
            if (got.tilt_y !== e.tilt_y) begin
                $error("tilt_y expected %0d actual %0d", $signed(e.tilt_y), $signed(got.tilt_y));
                errs++;
            end
            if (got.vibration !== e.vibration) begin
                $error("vibration expected %0d actual %0d", e.vibration, got.vibration);
                errs++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic signed [AXIS_W-1:0] i_accel_x = '0;
    logic signed [AXIS_W-1:0] i_accel_y = '0;
    logic signed [AXIS_W-1:0] i_accel_z = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [TILT_W-1:0] o_tilt_x;
    logic signed [TILT_W-1:0] o_tilt_y;
    logic [VIB_W-1:0]         o_vibration;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [ONEG_W-1:0]        i_cfg_data = '0;

    tilt_vib_board board = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    accel_tilt_and_vibration u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Give up if the run takes far longer than the slowest correct one.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == 400000) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Result side: check accepted results, then choose the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_result({o_tilt_x, o_tilt_y, o_vibration});
        end
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Send one sample request, idling first as the phase asks.
    task automatic send_sample(input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
                               input logic [AXIS_W-1:0] z);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_accel_x <= x;
        i_accel_y <= y;
        i_accel_z <= z;
        do @(posedge i_clk); while (o_stall);
        board.note_sample(x, y, z);
    endtask

    // Drain all results and let the pipeline settle before a register write.
    task automatic drain();
        i_valid <= 1'b0;
        while (board.pending_tilts.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_one_g(input logic [ONEG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.one_g = value;
        i_cfg_valid <= 1'b0;
    endtask

    // One random axis count: small, full range, corner values or near one g.
    function automatic logic [AXIS_W-1:0] pick_axis(input int kind, input bit major);
        logic [AXIS_W-1:0] corners[6] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001,
                                          16'h7FFF, 16'h8001};
        case (kind)
            0: return AXIS_W'($urandom_range(0, 4095) - 2048);
            1: return AXIS_W'($urandom);
            2: return corners[$urandom_range(0, 5)];
            default: begin
                if (major)
                    return AXIS_W'(($urandom_range(0, 1) ? 16384 : -16384)
                                   + int'($urandom_range(0, 2047)) - 1024);
                return AXIS_W'($urandom_range(0, 2047) - 1024);
            end
        endcase
    endfunction

    task automatic random_samples(input int count);
        int kind, major;
        for (int n = 0; n < count; n++) begin
            kind  = $urandom_range(0, 5);
            major = $urandom_range(0, 2);
            send_sample(pick_axis(kind, major == 0), pick_axis(kind, major == 1),
                        pick_axis(kind, major == 2));
        end
    endtask

    initial begin
        int idle_set[4]  = '{0, 48, 0, 36};
        int stall_set[4] = '{0, 0, 48, 36};
        logic [ONEG_W-1:0] g_set[5] = '{15'd1, 15'd32767, 15'd16384, 15'd8192, 15'd0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners at the reset value of one g.
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h8000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h8000);
        send_sample(16'h7FFF, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h7FFF, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h7FFF);
        send_sample(16'h0000, 16'h0000, 16'h4000);
        send_sample(16'h0000, 16'h0000, 16'hC000);
        send_sample(16'h4000, 16'h4000, 16'h0000);
        send_sample(16'hC000, 16'h4000, 16'h4000);
        send_sample(16'h0001, 16'hFFFF, 16'h0000);
        send_sample(16'hFFFF, 16'h0001, 16'h0001);
        send_sample(16'h8000, 16'h7FFF, 16'h0001);
        send_sample(16'h0000, 16'h0001, 16'h7FFF);
        send_sample(16'h0001, 16'h0000, 16'h8000);
        send_sample(16'h5A82, 16'h0000, 16'h5A82);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Phases over settings of one g and of idling on both sides.
        for (int p = 0; p < 5; p++) begin
            drain();
            write_one_g(g_set[p]);
            for (int m = 0; m < 4; m++) begin
                send_idle_pct  = idle_set[m];
                recv_stall_pct = stall_set[m];
                random_samples(80);
            end
        end
        send_idle_pct = 0;
        drain();
        recv_stall_pct = 0;

        if (board.errs == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
